@@ rtl/ssrl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo slew rate limiter package
// Shared widths, register indexes and reset values for the limiter and its
// serial divider.
// ----------------------------------------------------------------------------
package ssrl_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    localparam int CMD_W   = 16;
    localparam int PHYS_W  = 32;
    localparam int SLEW_W  = 31;
    localparam int TICK_W  = 16;
    localparam int TICK_FRAC = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Divider operand widths: the magnitude of the scaled product stays below 2^48.
    localparam int DVD_W = 48;
    localparam int DVS_W = 16;
    localparam int DIV_ITER = DVD_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_ITER);

    localparam int CMD_MIN_RST    = -128;
    localparam int CMD_MAX_RST    = 128;
    localparam int PHYS_RST_UNITS = 15;
    localparam int SLEW_RST_UNITS = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CMD_MIN  = 3'd0,
        REG_CMD_MAX  = 3'd1,
        REG_PHYS_MIN = 3'd2,
        REG_PHYS_MAX = 3'd3,
        REG_SLEW     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage
`default_nettype wire

@@ rtl/ssrl_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division that retires two quotient bits per cycle.
// ----------------------------------------------------------------------------
module ssrl_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [ssrl_pkg::DVD_W-1:0]   dividend,
    input  wire logic [ssrl_pkg::DVS_W-1:0]   divisor,
    output ssrl_pkg::div_status_t             status,
    output logic      [ssrl_pkg::DVD_W-1:0]   quotient
);

    logic [ssrl_pkg::DVD_W-1:0]     quot_reg, quot_next;
    logic [ssrl_pkg::DVS_W-1:0]     rem_reg, rem_next;
    logic [ssrl_pkg::DVS_W-1:0]     dvs_reg;
    logic [ssrl_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [ssrl_pkg::DVS_W:0] r1, r2, sub1, sub2;
    logic [ssrl_pkg::DVS_W-1:0] rem1;
    logic ge1, ge2;

    always_comb begin
        r1   = {rem_reg, quot_reg[ssrl_pkg::DVD_W-1]};
        sub1 = r1 - {1'b0, dvs_reg};
        ge1  = (r1 >= {1'b0, dvs_reg});
        rem1 = ge1 ? sub1[ssrl_pkg::DVS_W-1:0] : r1[ssrl_pkg::DVS_W-1:0];
        r2   = {rem1, quot_reg[ssrl_pkg::DVD_W-2]};
        sub2 = r2 - {1'b0, dvs_reg};
        ge2  = (r2 >= {1'b0, dvs_reg});
        rem_next  = ge2 ? sub2[ssrl_pkg::DVS_W-1:0] : r2[ssrl_pkg::DVS_W-1:0];
        quot_next = {quot_reg[ssrl_pkg::DVD_W-3:0], ge1, ge2};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ssrl_pkg::DIV_CNT_W'(ssrl_pkg::DIV_ITER - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quot_reg;

endmodule
`default_nettype wire

@@ rtl/servo_slew_rate_limiter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo slew rate limiter
// Clamps and holds a command, maps it onto a physical range on each tick and
// moves the position toward that target at a limited rate.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  s_       in         tdata: command_value, tick_duration; tuser: command
//  m_       out        tdata: position, held_command
//  cfg_     in         cfg_index, cfg_data (register write)
//
//  A write item stores the clamped command; a tick forms the step product and,
//  with a positive command range, the range product and its quotient from the
//  serial divider, which sets the tick time, then the target and the position.
//  Each ends in the done state, registering the result when the output is free.
//  A finished result waits in the output register while the next item is
//  taken; a stalled result holds the next one in the done state.
//  Reset is synchronous: registers return to their defaults, state to idle.
// ----------------------------------------------------------------------------
module servo_slew_rate_limiter #(
    parameter int FRACTION_BITS = ssrl_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [31:0]                       s_tdata,  // command_value, tick_duration
    input  wire logic [0:0]                        s_tuser,  // command
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [47:0]                       m_tdata,  // position, held_command
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ssrl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ssrl_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam logic [ssrl_pkg::PHYS_W-1:0] PHYS_MAX_RST =
        ssrl_pkg::PHYS_W'(ssrl_pkg::PHYS_RST_UNITS << FRACTION_BITS);
    localparam logic [ssrl_pkg::PHYS_W-1:0] PHYS_MIN_RST =
        ssrl_pkg::PHYS_W'(-(ssrl_pkg::PHYS_RST_UNITS << FRACTION_BITS));
    localparam logic [ssrl_pkg::SLEW_W-1:0] SLEW_RST =
        ssrl_pkg::SLEW_W'(ssrl_pkg::SLEW_RST_UNITS << FRACTION_BITS);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_STEP_MUL = 8'b0000_0010,
        ST_PROD_MUL = 8'b0000_0100,
        ST_DIV_LOAD = 8'b0000_1000,
        ST_DIV_WAIT = 8'b0001_0000,
        ST_TARGET   = 8'b0010_0000,
        ST_MOVE     = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg;

    logic signed [ssrl_pkg::CMD_W-1:0]  cmd_min_reg, cmd_max_reg;
    logic signed [ssrl_pkg::PHYS_W-1:0] phys_min_reg, phys_max_reg;
    logic        [ssrl_pkg::SLEW_W-1:0] slew_reg;

    logic signed [ssrl_pkg::CMD_W-1:0]  stored_cmd_reg;
    logic signed [ssrl_pkg::PHYS_W-1:0] pos_reg;
    logic        [ssrl_pkg::TICK_W-1:0] dt_reg;
    logic        [ssrl_pkg::SLEW_W-1:0] step_reg;
    logic signed [49:0]                 prod_reg;
    logic signed [48:0]                 q_reg;
    logic signed [ssrl_pkg::PHYS_W-1:0] target_reg;
    logic                               m_tvalid_reg;
    logic        [47:0]                 m_tdata_reg;

    logic signed [ssrl_pkg::CMD_W-1:0]  in_cmd_value;
    logic signed [ssrl_pkg::CMD_W-1:0]  clamped;
    logic                               s_accept;
    logic signed [16:0]                 span;
    logic                               span_pos;
    logic signed [32:0]                 mul_a;
    logic signed [16:0]                 mul_b;
    logic signed [49:0]                 mul_p;
    logic signed [49:0]                 prod_abs;
    logic signed [49:0]                 tgt_sum;
    logic signed [32:0]                 pos_up, pos_dn, tgt_ext;
    logic signed [ssrl_pkg::PHYS_W-1:0] pos_new;
    logic                               div_start;
    ssrl_pkg::div_status_t              div_status;
    logic        [ssrl_pkg::DVD_W-1:0]  div_quot;
    logic                               out_free;

    assign s_accept     = s_tvalid && s_tready;
    assign s_tready     = (state_reg == ST_IDLE);
    assign in_cmd_value = s_tdata[15:0];
    assign out_free     = !m_tvalid_reg || m_tready;
    assign cfg_ready    = 1'b1;
    assign div_start    = (state_reg == ST_DIV_LOAD);

    always_comb begin
        if (in_cmd_value > cmd_max_reg) begin
            clamped = cmd_max_reg;
        end else if (in_cmd_value < cmd_min_reg) begin
            clamped = cmd_min_reg;
        end else begin
            clamped = in_cmd_value;
        end
    end

    assign span     = {cmd_max_reg[15], cmd_max_reg} - {cmd_min_reg[15], cmd_min_reg};
    assign span_pos = !span[16] && (span != '0);

    // One multiplier serves the step product and the range scaling.
    always_comb begin
        if (state_reg == ST_STEP_MUL) begin
            mul_a = {2'b00, slew_reg};
            mul_b = {1'b0, dt_reg};
        end else begin
            mul_a = {phys_max_reg[31], phys_max_reg} - {phys_min_reg[31], phys_min_reg};
            mul_b = {stored_cmd_reg[15], stored_cmd_reg} - {cmd_min_reg[15], cmd_min_reg};
        end
        mul_p = mul_a * mul_b;
    end

    assign prod_abs = prod_reg[49] ? -prod_reg : prod_reg;
    assign tgt_sum  = {{18{phys_min_reg[31]}}, phys_min_reg} + {q_reg[48], q_reg};

    always_comb begin
        tgt_ext = {target_reg[31], target_reg};
        pos_up  = {pos_reg[31], pos_reg} + {2'b00, step_reg};
        pos_dn  = {pos_reg[31], pos_reg} - {2'b00, step_reg};
        if (pos_reg < target_reg) begin
            pos_new = (pos_up > tgt_ext) ? target_reg : pos_up[31:0];
        end else if (pos_reg > target_reg) begin
            pos_new = (pos_dn < tgt_ext) ? target_reg : pos_dn[31:0];
        end else begin
            pos_new = pos_reg;
        end
    end

    ssrl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_abs[ssrl_pkg::DVD_W-1:0]),
        .divisor  (span[ssrl_pkg::DVS_W-1:0]),
        .status   (div_status),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_min_reg  <= ssrl_pkg::CMD_W'(ssrl_pkg::CMD_MIN_RST);
            cmd_max_reg  <= ssrl_pkg::CMD_W'(ssrl_pkg::CMD_MAX_RST);
            phys_min_reg <= PHYS_MIN_RST;
            phys_max_reg <= PHYS_MAX_RST;
            slew_reg     <= SLEW_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ssrl_pkg::REG_CMD_MIN:  cmd_min_reg  <= cfg_data[15:0];
                ssrl_pkg::REG_CMD_MAX:  cmd_max_reg  <= cfg_data[15:0];
                ssrl_pkg::REG_PHYS_MIN: phys_min_reg <= cfg_data;
                ssrl_pkg::REG_PHYS_MAX: phys_max_reg <= cfg_data;
                ssrl_pkg::REG_SLEW:     slew_reg     <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            stored_cmd_reg <= '0;
            pos_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (s_tuser[0]) begin
                            state_reg <= ST_STEP_MUL;
                        end else begin
                            stored_cmd_reg <= clamped;
                            state_reg      <= ST_DONE;
                        end
                    end
                end
                ST_STEP_MUL: begin
                    state_reg <= span_pos ? ST_PROD_MUL : ST_TARGET;
                end
                ST_PROD_MUL: state_reg <= ST_DIV_LOAD;
                ST_DIV_LOAD: state_reg <= ST_DIV_WAIT;
                ST_DIV_WAIT: begin
                    if (div_status.done) begin
                        state_reg <= ST_TARGET;
                    end
                end
                ST_TARGET: state_reg <= ST_MOVE;
                ST_MOVE: begin
                    pos_reg   <= pos_new;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            dt_reg <= s_tdata[31:16];
        end
        if (state_reg == ST_STEP_MUL) begin
            step_reg <= mul_p[ssrl_pkg::TICK_FRAC +: ssrl_pkg::SLEW_W];
        end
        if (state_reg == ST_PROD_MUL) begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_DIV_WAIT && div_status.done) begin
            q_reg <= prod_reg[49] ? -{1'b0, div_quot} : {1'b0, div_quot};
        end
        if (state_reg == ST_TARGET) begin
            if (!span_pos) begin
                target_reg <= phys_min_reg;
            end else if (tgt_sum[49:31] != {19{tgt_sum[49]}}) begin
                target_reg <= tgt_sum[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                target_reg <= tgt_sum[31:0];
            end
        end
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= {stored_cmd_reg, pos_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    a_write_stores_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !s_tuser[0] |=> stored_cmd_reg == $past(clamped))
        else $error("write item did not store the clamped command");

    a_div_only_positive_span: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> span_pos && !div_status.busy)
        else $error("divider started with a non-positive span or while busy");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");
`endif

endmodule
`default_nettype wire

@@ verif/servo_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo limiter verification package
// Item kinds carried in tuser, shared by the stimulus and the result checker.
// ----------------------------------------------------------------------------
package servo_tb_pkg;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } servo_op_t;

endpackage

@@ verif/servo_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo limiter result checker
// Follows register writes and accepted input items, predicts the held command
// and the position each item must return, and compares every result item in
// order against those predictions.
// ----------------------------------------------------------------------------
module servo_result_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [31:0]                     s_tdata,  // command_value, tick_duration
    input  wire logic [0:0]                      s_tuser,  // command
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [47:0]                     m_tdata,  // position, held_command
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [ssrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ssrl_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   results_checked
);

    localparam int REPORT_LIMIT = 40;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [15:0] held_command;
    } servo_result_t;

    logic signed [15:0] cmd_lo;
    logic signed [15:0] cmd_hi;
    logic signed [31:0] phys_lo;
    logic signed [31:0] phys_hi;
    logic        [30:0] slew_rate;
    logic signed [15:0] held_cmd;
    logic signed [31:0] position;
    servo_result_t      expected_results[$];

    function automatic logic signed [31:0] target_of_command();
        longint span;
        longint prod;
        longint goal;
        span = longint'(cmd_hi) - longint'(cmd_lo);
        if (span <= 0) begin
            return phys_lo;
        end
        prod = (longint'(held_cmd) - longint'(cmd_lo)) *
               (longint'(phys_hi) - longint'(phys_lo));
        goal = longint'(phys_lo) + prod / span;
        if (goal > 64'sd2147483647) begin
            goal = 64'sd2147483647;
        end else if (goal < -64'sd2147483648) begin
            goal = -64'sd2147483648;
        end
        return goal[31:0];
    endfunction

    function automatic servo_result_t advance_servo(input servo_tb_pkg::servo_op_t op,
                                                    input logic signed [15:0] req,
                                                    input logic [15:0] dt);
        longint step;
        longint goal;
        longint next;
        servo_result_t res;
        if (op == servo_tb_pkg::OP_WRITE) begin
            if (req > cmd_hi) begin
                held_cmd = cmd_hi;
            end else if (req < cmd_lo) begin
                held_cmd = cmd_lo;
            end else begin
                held_cmd = req;
            end
        end else begin
            step = (longint'(slew_rate) * longint'(dt)) >>> ssrl_pkg::TICK_FRAC;
            goal = longint'(target_of_command());
            next = longint'(position);
            if (next < goal) begin
                next = next + step;
                if (next > goal) begin
                    next = goal;
                end
            end else if (next > goal) begin
                next = next - step;
                if (next < goal) begin
                    next = goal;
                end
            end
            position = next[31:0];
        end
        res.position = position;
        res.held_command = held_cmd;
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        servo_result_t want;
        servo_result_t got;
        if (!aresetn) begin
            cmd_lo = 16'(ssrl_pkg::CMD_MIN_RST);
            cmd_hi = 16'(ssrl_pkg::CMD_MAX_RST);
            phys_lo = -(ssrl_pkg::PHYS_RST_UNITS <<< ssrl_pkg::FRACTION_BITS_DEF);
            phys_hi = ssrl_pkg::PHYS_RST_UNITS <<< ssrl_pkg::FRACTION_BITS_DEF;
            slew_rate = 31'(ssrl_pkg::SLEW_RST_UNITS << ssrl_pkg::FRACTION_BITS_DEF);
            held_cmd = '0;
            position = '0;
            expected_results.delete();
            fail_count = 0;
            results_checked = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ssrl_pkg::REG_CMD_MIN:  cmd_lo = cfg_data[15:0];
                    ssrl_pkg::REG_CMD_MAX:  cmd_hi = cfg_data[15:0];
                    ssrl_pkg::REG_PHYS_MIN: phys_lo = cfg_data;
                    ssrl_pkg::REG_PHYS_MAX: phys_hi = cfg_data;
                    ssrl_pkg::REG_SLEW:     slew_rate = cfg_data[30:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.position = m_tdata[31:0];
                got.held_command = m_tdata[47:32];
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $error("result item with nothing expected: position %0d, held_command %0d",
                               got.position, got.held_command);
                    end
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got.position !== want.position) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $error("position: expected %0d, got %0d",
                                   want.position, got.position);
                        end
                    end
                    if (got.held_command !== want.held_command) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $error("held_command: expected %0d, got %0d",
                                   want.held_command, got.held_command);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(
                    advance_servo(servo_tb_pkg::servo_op_t'(s_tuser[0]),
                                  s_tdata[15:0], s_tdata[31:16]));
            end
        end
        pending <= expected_results.size();
    end

endmodule

@@ verif/tb_servo_slew_rate_limiter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo slew rate limiter testbench
// Runs directed items over the clamping, range and saturation corners, then
// random phases, each under a new register setting. The sender pauses in
// bursts and the receiver stalls in changing patterns while the checker
// compares every result item.
// ----------------------------------------------------------------------------
module tb_servo_slew_rate_limiter;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 10;
    localparam int RAND_PHASES     = 14;
    localparam int ITEMS_PER_PHASE = 138;
    localparam int IDLE_LIMIT      = 2000;
    localparam int SETTLE_CYCLES   = 40;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_MOSTLY,
        READY_SPARSE
    } stall_mode_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [31:0]                     s_tdata = '0;   // command_value, tick_duration
    logic [0:0]                      s_tuser = '0;   // command
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [47:0]                     m_tdata;        // position, held_command
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [ssrl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ssrl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    int          fail_count;
    int          pending;
    int          results_checked;
    int          writes_sent = 0;
    int          ticks_sent = 0;
    int          settings_applied = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    int          cur_lo = ssrl_pkg::CMD_MIN_RST;
    int          cur_hi = ssrl_pkg::CMD_MAX_RST;
    stall_mode_t stall_mode = READY_ALWAYS;
    int          stall_left = 0;
    logic [3:0]  stall_phase = '0;

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    servo_slew_rate_limiter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    servo_result_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1'b1;
        if (stall_left == 0) begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(50, 400);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_RANDOM: m_tready <= 1'($urandom_range(0, 1));
            READY_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
            default:      m_tready <= (stall_phase < 4'd3);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no item accepted for %0d cycles.", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic load_register(input logic [ssrl_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [ssrl_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Upper bits of the command registers are don't-care, so they get noise.
    task automatic program_regs(input logic [15:0] cmd_min, input logic [15:0] cmd_max,
                                input logic [31:0] phys_min, input logic [31:0] phys_max,
                                input logic [31:0] slew, input bit with_unused);
        load_register(ssrl_pkg::REG_CMD_MIN, ($urandom() & 32'hFFFF_0000) | cmd_min);
        load_register(ssrl_pkg::REG_CMD_MAX, ($urandom() & 32'hFFFF_0000) | cmd_max);
        load_register(ssrl_pkg::REG_PHYS_MIN, phys_min);
        load_register(ssrl_pkg::REG_PHYS_MAX, phys_max);
        load_register(ssrl_pkg::REG_SLEW, slew);
        if (with_unused) begin
            for (int i = ssrl_pkg::REG_SLEW + 1; i < (1 << ssrl_pkg::CFG_IDX_W); i++) begin
                load_register(i[ssrl_pkg::CFG_IDX_W-1:0], $urandom());
            end
        end
        cfg_valid <= 1'b0;
        cur_lo = $signed(cmd_min);
        cur_hi = $signed(cmd_max);
        settings_applied++;
    endtask

    task automatic send_item(input servo_tb_pkg::servo_op_t op, input logic [15:0] req,
                             input logic [15:0] dt);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {dt, req};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        if (op == servo_tb_pkg::OP_WRITE) begin
            writes_sent++;
        end else begin
            ticks_sent++;
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic random_settings();
        int          lo;
        int          hi;
        logic [31:0] phys_a;
        logic [31:0] phys_b;
        logic [31:0] slew;
        case ($urandom_range(0, 9))
            0: begin
                lo = -32768;
                hi = 32767;
            end
            1: begin
                lo = $urandom_range(0, 200) - 100;
                hi = lo;
            end
            2: begin
                hi = $urandom_range(0, 200) - 100;
                lo = hi + $urandom_range(1, 100);
            end
            3: begin
                lo = $urandom_range(0, 65535) - 32768;
                hi = $urandom_range(0, 65535) - 32768;
            end
            default: begin
                lo = $urandom_range(0, 600) - 300;
                hi = lo + $urandom_range(1, 500);
            end
        endcase
        case ($urandom_range(0, 5))
            0: begin
                phys_a = 32'h8000_0000;
                phys_b = 32'h7FFF_FFFF;
            end
            1: begin
                phys_a = 32'h7FFF_FFFF;
                phys_b = 32'h8000_0000;
            end
            2: begin
                phys_a = $urandom();
                phys_b = $urandom();
            end
            default: begin
                phys_a = $urandom_range(0, 64 << 16) - (32 << 16);
                phys_b = $urandom_range(0, 64 << 16) - (32 << 16);
            end
        endcase
        case ($urandom_range(0, 5))
            0:       slew = '0;
            1:       slew = 32'hFFFF_FFFF;
            2:       slew = $urandom();
            default: slew = $urandom() >> $urandom_range(4, 16);
        endcase
        program_regs(lo[15:0], hi[15:0], phys_a, phys_b, slew, $urandom_range(0, 2) == 0);
    endtask

    // Most writes land near the command range so the clamp edges get exercised.
    task automatic random_item();
        int         lo;
        int         hi;
        int         req;
        logic [15:0] dt;
        lo = ((cur_lo < cur_hi) ? cur_lo : cur_hi) - 8;
        hi = ((cur_lo < cur_hi) ? cur_hi : cur_lo) + 8;
        if (lo < -32768) begin
            lo = -32768;
        end
        if (hi > 32767) begin
            hi = 32767;
        end
        if ($urandom_range(0, 9) < 7) begin
            req = lo + $urandom_range(0, hi - lo);
        end else begin
            req = $urandom_range(0, 65535);
        end
        case ($urandom_range(0, 9))
            0:       dt = '0;
            1:       dt = 16'hFFFF;
            default: dt = 16'($urandom()) >> $urandom_range(0, 12);
        endcase
        send_item(($urandom_range(0, 99) < 55) ? servo_tb_pkg::OP_TICK : servo_tb_pkg::OP_WRITE,
                  req[15:0], dt);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: overshoot limiting, clamping at both ends, zero tick.
        send_item(servo_tb_pkg::OP_TICK, 16'h7FFF, 16'hFFFF);
        send_item(servo_tb_pkg::OP_WRITE, 16'h7FFF, 16'hFFFF);
        send_item(servo_tb_pkg::OP_TICK, 16'h8000, 16'h0000);
        send_item(servo_tb_pkg::OP_TICK, 16'h0000, 16'hFFFF);
        send_item(servo_tb_pkg::OP_TICK, 16'hFFFF, 16'hFFFF);
        send_item(servo_tb_pkg::OP_WRITE, 16'h8000, 16'h0000);
        send_item(servo_tb_pkg::OP_TICK, 16'h8000, 16'h8000);
        send_item(servo_tb_pkg::OP_TICK, 16'h1234, 16'h0001);
        send_item(servo_tb_pkg::OP_WRITE, 16'h0000, 16'h5555);
        send_item(servo_tb_pkg::OP_WRITE, 16'h0001, 16'hAAAA);
        send_item(servo_tb_pkg::OP_TICK, 16'hFFFF, 16'hFFFF);
        wait_drained();

        // Inverted command range: clamp order decides, target is the minimum.
        program_regs(16'd10, -16'sd10, 32'h0003_0000, 32'hFFF0_0000, 32'h7FFF_FFFF, 1'b1);
        send_item(servo_tb_pkg::OP_WRITE, 16'h0000, 16'h0000);
        send_item(servo_tb_pkg::OP_WRITE, -16'sd20, 16'hFFFF);
        send_item(servo_tb_pkg::OP_WRITE, 16'd20, 16'h0000);
        send_item(servo_tb_pkg::OP_TICK, 16'h7FFF, 16'hFFFF);
        wait_drained();

        // Full command range onto an inverted full physical range.
        program_regs(16'h8000, 16'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_item(servo_tb_pkg::OP_WRITE, 16'h8000, 16'h0000);
        send_item(servo_tb_pkg::OP_TICK, 16'h0000, 16'hFFFF);
        send_item(servo_tb_pkg::OP_WRITE, 16'h7FFF, 16'h0000);
        send_item(servo_tb_pkg::OP_TICK, 16'h0000, 16'hFFFF);
        send_item(servo_tb_pkg::OP_TICK, 16'h0000, 16'hFFFF);
        wait_drained();

        // Held command far outside a narrow new range saturates the target.
        program_regs(16'h8000, 16'h8001, 32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_item(servo_tb_pkg::OP_TICK, 16'h0000, 16'hFFFF);
        send_item(servo_tb_pkg::OP_TICK, 16'h0000, 16'hFFFF);
        wait_drained();

        // Empty command range.
        program_regs(16'd5, 16'd5, 32'hFFFD_0000, 32'h0040_0000, 32'h000A_0000, 1'b0);
        send_item(servo_tb_pkg::OP_WRITE, 16'd100, 16'h0000);
        send_item(servo_tb_pkg::OP_TICK, 16'h0000, 16'hFFFF);
        send_item(servo_tb_pkg::OP_WRITE, -16'sd100, 16'h0000);
        wait_drained();

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            random_settings();
            repeat (ITEMS_PER_PHASE) random_item();
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d write items and %0d tick items under %0d register settings.",
                 writes_sent, ticks_sent, settings_applied);
        $display("Checked %0d result items.", results_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/ssrl_pkg.sv
rtl/ssrl_div.sv
rtl/servo_slew_rate_limiter.sv
verif/servo_tb_pkg.sv
verif/servo_result_checker.sv
verif/tb_servo_slew_rate_limiter.sv
